>>> src/etmm_pkg.sv
// Package: formats, constants and CORDIC arctangent table for the model matrix builder.
package etmm_pkg;

  // Iterations of the sine/cosine CORDIC, 8 to 24
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;

  // Bus widths
  localparam int IN_BITS  = 240;
  localparam int OUT_BITS = 384;

  // Angle and rotation words
  localparam int ZW = 34;   // Q.29 angle accumulator
  localparam int XW = 33;   // Q.30 CORDIC x / y
  localparam int SW = 32;   // Q.30 sine / cosine after fold-back
  localparam int MW = 33;   // Q.30 product
  localparam int EW = 34;   // Q.30 matrix element

  localparam logic signed [XW-1:0] GAIN_Q30    = XW'(652032874);
  localparam logic signed [ZW-1:0] PI_Q29      = ZW'(1686629713);
  localparam logic signed [ZW-1:0] HALF_PI_Q29 = ZW'(843314857);

  // atan(2^-i), Q.29 radians
  localparam logic signed [31:0] ATAN_Q29 [ATAN_ENTRIES] = '{
    32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
    32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
    32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
    32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
    32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
    32'sd512,       32'sd256,       32'sd128,       32'sd64
  };

  // Pass-through fields of one item
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } pass_t;

endpackage

>>> src/euler_trs_model_matrix.sv
// Top level: pipelined model matrix builder (T * R * S) with three CORDIC lanes.
//
//  channel   dir  handshake                          payload
//  s_axis    in   s_axis_tvalid / s_axis_tready      pos, angles, scales (240 bits)
//  m_axis    out  m_axis_tvalid / m_axis_tready      three matrix rows (384 bits)
//
// One item per cycle while the output is not stalled; the stages are fold, one CORDIC
// iteration per stage, sign fix, two product stages, sum, scale multiply, round.
// rst_ni clears all valid bits asynchronously; payload registers are not reset.
// A stalled output freezes every stage together, so nothing is lost or repeated;
// while the output register is empty or being taken the whole pipeline advances.
module euler_trs_model_matrix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pos_x, pos_y, pos_z, angle_yaw, angle_pitch, angle_roll, scale_x, scale_y, scale_z
  input  logic [etmm_pkg::IN_BITS-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // r0c0, r0c1, r0c2, trans_x, r1c0, r1c1, r1c2, trans_y, r2c0, r2c1, r2c2, trans_z
  output logic [etmm_pkg::OUT_BITS-1:0] m_axis_tdata
);
  import etmm_pkg::*;

  localparam int NC   = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int S_E  = NC + 4;   // elements
  localparam int S_P  = NC + 5;   // scale products
  localparam int NST  = NC + 7;   // stages incl. output register

  logic adv;
  logic [NST-1:0] vld_q;
  pass_t pass_q [NST-1];

  // Pipeline moves unless a finished result is waiting
  assign adv           = !(m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // Input fields
  pass_t in_pass;
  logic signed [15:0] ang_in [3];
  always_comb begin
    in_pass.pos_x   = s_axis_tdata[31:0];
    in_pass.pos_y   = s_axis_tdata[63:32];
    in_pass.pos_z   = s_axis_tdata[95:64];
    ang_in[0]       = s_axis_tdata[111:96];
    ang_in[1]       = s_axis_tdata[127:112];
    ang_in[2]       = s_axis_tdata[143:128];
    in_pass.scale_x = s_axis_tdata[175:144];
    in_pass.scale_y = s_axis_tdata[207:176];
    in_pass.scale_z = s_axis_tdata[239:208];
  end

  // Pass-through fields ride along
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pass_q[0] <= in_pass;
      for (int k = 1; k < NST - 1; k++) pass_q[k] <= pass_q[k-1];
    end
  end

  // Lanes: 0 yaw, 1 pitch, 2 roll
  logic signed [XW-1:0] cx_q [NC+1][3];
  logic signed [XW-1:0] cy_q [NC+1][3];
  logic signed [ZW-1:0] cz_q [NC+1][3];
  logic                 flip_q [NC+1][3];

  // Stage 0: widen to Q.29 and fold into +-pi/2
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        logic signed [ZW-1:0] z;
        z = {{(ZW-32){ang_in[l][15]}}, ang_in[l], 16'b0};
        cx_q[0][l] <= GAIN_Q30;
        cy_q[0][l] <= '0;
        if (z > HALF_PI_Q29) begin
          cz_q[0][l]   <= z - PI_Q29;
          flip_q[0][l] <= 1'b1;
        end else if (z < -HALF_PI_Q29) begin
          cz_q[0][l]   <= z + PI_Q29;
          flip_q[0][l] <= 1'b1;
        end else begin
          cz_q[0][l]   <= z;
          flip_q[0][l] <= 1'b0;
        end
      end
    end
  end

  // One CORDIC iteration per stage
  for (genvar i = 0; i < NC; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          flip_q[i+1][l] <= flip_q[i][l];
          if (!cz_q[i][l][ZW-1]) begin
            cx_q[i+1][l] <= cx_q[i][l] - (cy_q[i][l] >>> i);
            cy_q[i+1][l] <= cy_q[i][l] + (cx_q[i][l] >>> i);
            cz_q[i+1][l] <= cz_q[i][l] - ZW'(ATAN_Q29[i]);
          end else begin
            cx_q[i+1][l] <= cx_q[i][l] + (cy_q[i][l] >>> i);
            cy_q[i+1][l] <= cy_q[i][l] - (cx_q[i][l] >>> i);
            cz_q[i+1][l] <= cz_q[i][l] + ZW'(ATAN_Q29[i]);
          end
        end
      end
    end
  end

  // Sign fix for folded angles
  logic signed [SW-1:0] sin_q [3];
  logic signed [SW-1:0] cos_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        if (flip_q[NC][l]) begin
          sin_q[l] <= SW'(-cy_q[NC][l]);
          cos_q[l] <= SW'(-cx_q[NC][l]);
        end else begin
          sin_q[l] <= SW'(cy_q[NC][l]);
          cos_q[l] <= SW'(cx_q[NC][l]);
        end
      end
    end
  end

  function automatic logic signed [MW-1:0] mq30(input logic signed [SW-1:0] a,
                                                 input logic signed [SW-1:0] b);
    logic signed [2*SW:0] p;
    p = (2*SW+1)'(a * b) + (2*SW+1)'(64'sd1 <<< 29);
    return MW'(p >>> 30);
  endfunction

  // First products
  logic signed [SW-1:0] sr1_q, cr1_q, sp1_q;
  logic signed [MW-1:0] spsy_q, spcy_q, crcy_q, srcp_q, crsy_q, crcp_q, srsy_q,
                        cpcy_q, cpsy_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sr1_q  <= sin_q[2];
      cr1_q  <= cos_q[2];
      sp1_q  <= sin_q[1];
      spsy_q <= mq30(sin_q[1], sin_q[0]);
      spcy_q <= mq30(sin_q[1], cos_q[0]);
      crcy_q <= mq30(cos_q[2], cos_q[0]);
      srcp_q <= mq30(sin_q[2], cos_q[1]);
      crsy_q <= mq30(cos_q[2], sin_q[0]);
      crcp_q <= mq30(cos_q[2], cos_q[1]);
      srsy_q <= mq30(sin_q[2], sin_q[0]);
      cpcy_q <= mq30(cos_q[1], cos_q[0]);
      cpsy_q <= mq30(cos_q[1], sin_q[0]);
    end
  end

  // Second products, others carried
  logic signed [MW-1:0] srspsy_q, crspsy_q, srspcy_q, crspcy_q;
  logic signed [MW-1:0] crcy2_q, srcp2_q, crsy2_q, crcp2_q, srsy2_q, cpcy2_q, cpsy2_q;
  logic signed [SW-1:0] sp2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      srspsy_q <= mq30(sr1_q, SW'(spsy_q));
      crspsy_q <= mq30(cr1_q, SW'(spsy_q));
      srspcy_q <= mq30(sr1_q, SW'(spcy_q));
      crspcy_q <= mq30(cr1_q, SW'(spcy_q));
      crcy2_q  <= crcy_q;
      srcp2_q  <= srcp_q;
      crsy2_q  <= crsy_q;
      crcp2_q  <= crcp_q;
      srsy2_q  <= srsy_q;
      cpcy2_q  <= cpcy_q;
      cpsy2_q  <= cpsy_q;
      sp2_q    <= sp1_q;
    end
  end

  // Row 1 column 0 needs sr*cy, carried alongside the other products
  logic signed [MW-1:0] srcy1_q, srcy2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      srcy1_q <= mq30(sin_q[2], cos_q[0]);
      srcy2_q <= srcy1_q;
    end
  end

  // Rotation elements, row-major
  logic signed [EW-1:0] e_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q[0] <= EW'(crcy2_q) - EW'(srspsy_q);
      e_q[1] <= -EW'(srcp2_q);
      e_q[2] <= EW'(crsy2_q) + EW'(srspcy_q);
      e_q[3] <= EW'(srcy2_q) + EW'(crspsy_q);
      e_q[4] <= EW'(crcp2_q);
      e_q[5] <= EW'(srsy2_q) - EW'(crspcy_q);
      e_q[6] <= -EW'(cpsy2_q);
      e_q[7] <= EW'(sp2_q);
      e_q[8] <= EW'(cpcy2_q);
    end
  end

  // Scale products
  localparam int PW = EW + 32;
  logic signed [PW-1:0] p_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 9; c++) begin
        logic signed [EW-1:0] e;
        logic signed [31:0]   sc;
        e = e_q[c];
        unique case (c % 3)
          0:       sc = pass_q[S_E].scale_x;
          1:       sc = pass_q[S_E].scale_y;
          default: sc = pass_q[S_E].scale_z;
        endcase
        p_q[c] <= PW'(e * sc);
      end
    end
  end

  function automatic logic [31:0] sat32(input logic signed [PW-1:0] v);
    if (v > PW'(64'sd2147483647)) return 32'h7fff_ffff;
    if (v < -PW'(64'sd2147483648)) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Round, saturate, output register
  logic [OUT_BITS-1:0] out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 9; c++) begin
        logic signed [PW-1:0] r;
        r = (p_q[c] + PW'(64'sd1 <<< 29)) >>> 30;
        out_q[(c/3)*128 + (c%3)*32 +: 32] <= sat32(r);
      end
      out_q[127:96]  <= pass_q[S_P].pos_x;
      out_q[255:224] <= pass_q[S_P].pos_y;
      out_q[383:352] <= sat32(-PW'(pass_q[S_P].pos_z));
    end
  end
  assign m_axis_tdata = out_q;

  // Assertions
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == !(m_axis_tvalid && !m_axis_tready))
    else $error("ready does not follow output stall");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(vld_q))
    else $error("pipeline moved during stall");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && vld_q[NST-2]) |=> m_axis_tvalid)
    else $error("result lost at output register");

endmodule

>>> tb/testbench.sv
// Testbench for the model matrix builder: random and directed transforms against a predictor.
`timescale 1ns / 100ps

module testbench;
  import etmm_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int LATENCY      = CORDIC_STAGES + 7;

  typedef struct packed {
    logic signed [31:0] scale_z;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_x;
    logic signed [15:0] angle_roll;
    logic signed [15:0] angle_pitch;
    logic signed [15:0] angle_yaw;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } pose_t;

  typedef logic signed [31:0] matrix_t [12];

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;

  logic [OUT_BITS-1:0] matrix_fifo [$];
  int                  n_errors = 0;
  int                  n_sent = 0;
  int                  n_checked = 0;
  int                  cycle_count = 0;
  int                  burst_left = 0;
  bit                  stall_mode = 1'b0;

  euler_trs_model_matrix dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Arithmetic shift right on 64-bit signed values
  function automatic longint sra64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return sra64(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Rotation-mode CORDIC with fold-back beyond a quarter turn
  task automatic cordic_sincos(input logic signed [15:0] ang, output longint s,
                               output longint c);
    longint z, x, y, nx;
    bit     flip;
    z = longint'(ang) * 65536;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 843314857) begin
      z -= 1686629713;
      flip = 1'b1;
    end else if (z < -843314857) begin
      z += 1686629713;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
      if (z >= 0) begin
        nx = x - sra64(y, i);
        y  = y + sra64(x, i);
        z -= longint'(ATAN_Q29[i]);
      end else begin
        nx = x + sra64(y, i);
        y  = y - sra64(x, i);
        z += longint'(ATAN_Q29[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  function automatic logic signed [31:0] apply_scale(longint e, logic signed [31:0] sc);
    return clamp32(sra64(e * longint'(sc) + (64'sd1 <<< 29), 30));
  endfunction

  // Expected T*R*S rows, packed in output order
  task automatic build_matrix(input pose_t p, output logic [OUT_BITS-1:0] packed_m);
    longint  sy, cy, sp, cp, sr, cr, spsy, spcy;
    matrix_t m;
    cordic_sincos(p.angle_yaw, sy, cy);
    cordic_sincos(p.angle_pitch, sp, cp);
    cordic_sincos(p.angle_roll, sr, cr);
    spsy = q30_mul(sp, sy);
    spcy = q30_mul(sp, cy);
    m[0]  = apply_scale(q30_mul(cr, cy) - q30_mul(sr, spsy), p.scale_x);
    m[1]  = apply_scale(-q30_mul(sr, cp), p.scale_y);
    m[2]  = apply_scale(q30_mul(cr, sy) + q30_mul(sr, spcy), p.scale_z);
    m[3]  = p.pos_x;
    m[4]  = apply_scale(q30_mul(sr, cy) + q30_mul(cr, spsy), p.scale_x);
    m[5]  = apply_scale(q30_mul(cr, cp), p.scale_y);
    m[6]  = apply_scale(q30_mul(sr, sy) - q30_mul(cr, spcy), p.scale_z);
    m[7]  = p.pos_y;
    m[8]  = apply_scale(-q30_mul(cp, sy), p.scale_x);
    m[9]  = apply_scale(sp, p.scale_y);
    m[10] = apply_scale(q30_mul(cp, cy), p.scale_z);
    m[11] = clamp32(-longint'(p.pos_z));
    for (int k = 0; k < 12; k++) packed_m[32*k +: 32] = m[k];
  endtask

  // Send one pose; gaps between random-length bursts
  task automatic send_pose(input pose_t p);
    logic [OUT_BITS-1:0] exp_m;
    int                  gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) * $urandom_range(0, 1);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    build_matrix(p, exp_m);
    s_axis_tdata  <= p;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    matrix_fifo.push_back(exp_m);
    n_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 25736));  // from zero up to pi
      2:       return -16'($urandom_range(0, 25736));
      default: return 16'($urandom_range(12800, 12940));
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($urandom_range(0, 32'h0004_0000));
      2:       return -32'($urandom_range(0, 32'h0004_0000));
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    p.pos_x = $urandom;
    p.pos_y = $urandom;
    p.pos_z = $urandom;
    p.angle_yaw = rand_angle();
    p.angle_pitch = rand_angle();
    p.angle_roll = rand_angle();
    p.scale_x = rand_scale();
    p.scale_y = rand_scale();
    p.scale_z = rand_scale();
    return p;
  endfunction

  // Extremes of every field, quarter-turn fold points and saturation
  task automatic test_directed();
    pose_t p;
    logic [15:0] angs [8] = '{16'h0000, 16'h7fff, 16'h8000, 16'd12868, 16'd12869,
                              -16'd12868, -16'd12869, 16'd25736};
    for (int i = 0; i < 8; i++) begin
      p = '{scale_z: 32'h0001_0000, scale_y: 32'h0001_0000, scale_x: 32'h0001_0000,
            angle_roll: angs[(i + 2) % 8], angle_pitch: angs[(i + 1) % 8],
            angle_yaw: angs[i], pos_z: 32'h0001_8000, pos_y: -32'sd5, pos_x: 32'd7};
      send_pose(p);
    end
    p = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h0000, 16'h0000, 16'h0000,
          32'h80000000, 32'h80000000, 32'h7fffffff};
    send_pose(p);
    p = '{32'h80000000, 32'h80000000, 32'h80000000, 16'h7fff, 16'h8000, 16'h7fff,
          32'h7fffffff, 32'h7fffffff, 32'h80000000};
    send_pose(p);
    p = '{32'hffffffff, 32'h0, 32'hffffffff, 16'hffff, 16'h0001, 16'hffff,
          32'h0, 32'hffffffff, 32'h0};
    send_pose(p);
    p = '{32'h0, 32'hffffffff, 32'h0, 16'h5555, 16'haaaa, 16'h5555,
          32'hffffffff, 32'h0, 32'hffffffff};
    send_pose(p);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_pose(rand_pose());
  endtask

  // Output side: stall pattern switching between free-running and choppy
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    m_axis_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  // Result checking against the oldest expected matrix
  always @(posedge clk_i) begin
    logic [OUT_BITS-1:0] exp_m;
    string names [12] = '{"r0c0", "r0c1", "r0c2", "trans_x", "r1c0", "r1c1", "r1c2",
                          "trans_y", "r2c0", "r2c1", "r2c2", "trans_z"};
    cycle_count++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (matrix_fifo.size() == 0) begin
        $error("unexpected output transfer");
        n_errors++;
      end else begin
        exp_m = matrix_fifo.pop_front();
        n_checked++;
        for (int k = 0; k < 12; k++)
          if (m_axis_tdata[32*k +: 32] !== exp_m[32*k +: 32]) begin
            $error("%s: expected %0d, got %0d", names[k], $signed(exp_m[32*k +: 32]),
                   $signed(m_axis_tdata[32*k +: 32]));
            n_errors++;
          end
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL euler_trs_model_matrix");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(1750);
    s_axis_tvalid <= 1'b0;
    while (matrix_fifo.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    $display("Sent %0d transforms (directed extremes, fold points, saturation, random),",
             n_sent);
    $display("checked %0d matrices under random input gaps and output stalls.", n_checked);
    if (n_errors == 0) begin
      $display("PASS euler_trs_model_matrix");
    end else begin
      $display("FAIL euler_trs_model_matrix");
    end
    $finish;
  end

endmodule
